// ===== rtl/cphu_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, request type and arctangent table for the phase unwrap block.
package cphu_pkg;

    localparam int DATA_BITS        = 16;
    localparam int PHASE_BITS       = 16;
    localparam int UNWRAP_BITS      = 40;
    localparam int OFFSET_BITS      = 24;
    localparam int ACC_BITS         = 32;
    localparam int ATAN_ENTRIES     = 24;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int FIFO_DEPTH       = 4;
    localparam int IN_TDATA_BITS    = 2 * DATA_BITS;
    localparam int OUT_TDATA_BITS   = UNWRAP_BITS + PHASE_BITS;

    typedef struct packed {
        logic                  first;
        logic [PHASE_BITS-1:0] raw;
    } t_phase_req;

    function automatic logic [ACC_BITS-1:0] atan_turn(input logic [4:0] k);
        logic [ACC_BITS-1:0] v;
        case (k)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/cphu_cordic.sv =====
`timescale 1ns / 1ps
// Front end: pipelined CORDIC arctangent, an input stage and then one rotation step per stage.
module cphu_cordic #(
    parameter int CORDIC_STEPS = cphu_pkg::DEF_CORDIC_STEPS,
    parameter int SAMPLE_BITS  = cphu_pkg::DEF_SAMPLE_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             i_en,
    input  logic [cphu_pkg::DATA_BITS-1:0]   i_sample_i,
    input  logic [cphu_pkg::DATA_BITS-1:0]   i_sample_q,
    input  logic                             i_first,
    output logic                             o_valid,
    output cphu_pkg::t_phase_req             o_req
);
    import cphu_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int W      = SAMPLE_BITS + 4;

    logic signed [SAMPLE_BITS-1:0] s_i;
    logic signed [SAMPLE_BITS-1:0] s_q;
    logic signed [W-1:0]           x_in;
    logic signed [W-1:0]           y_in;
    logic signed [W-1:0]           n_x0;
    logic signed [W-1:0]           n_y0;
    logic [ACC_BITS-1:0]           n_acc0;
    logic [ACC_BITS-1:0]           acc_rnd;

    logic signed [W-1:0]  r_x     [0:NSTEPS];
    logic signed [W-1:0]  r_y     [0:NSTEPS];
    logic [ACC_BITS-1:0]  r_acc   [0:NSTEPS];
    logic                 r_zero  [0:NSTEPS];
    logic                 r_first [0:NSTEPS];
    logic                 r_valid [0:NSTEPS];

    generate
        if (SAMPLE_BITS <= DATA_BITS) begin : g_narrow
            assign s_i = i_sample_i[SAMPLE_BITS-1:0];
            assign s_q = i_sample_q[SAMPLE_BITS-1:0];
        end else begin : g_wide
            assign s_i = {{(SAMPLE_BITS-DATA_BITS){1'b0}}, i_sample_i};
            assign s_q = {{(SAMPLE_BITS-DATA_BITS){1'b0}}, i_sample_q};
        end
    endgenerate

    assign x_in = {{2{s_i[SAMPLE_BITS-1]}}, s_i, 2'b00};
    assign y_in = {{2{s_q[SAMPLE_BITS-1]}}, s_q, 2'b00};

    // A sample in the left half plane is turned by half a turn first.
    always_comb begin
        if (x_in[W-1]) begin
            n_x0   = -x_in;
            n_y0   = -y_in;
            n_acc0 = {1'b1, {(ACC_BITS-1){1'b0}}};
        end else begin
            n_x0   = x_in;
            n_y0   = y_in;
            n_acc0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]     <= n_x0;
            r_y[0]     <= n_y0;
            r_acc[0]   <= n_acc0;
            r_zero[0]  <= (s_i == '0) && (s_q == '0);
            r_first[0] <= i_first;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NSTEPS; k++) begin : g_step
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k+1] <= r_valid[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (!r_y[k][W-1]) begin
                        r_x[k+1]   <= r_x[k] + (r_y[k] >>> k);
                        r_y[k+1]   <= r_y[k] - (r_x[k] >>> k);
                        r_acc[k+1] <= r_acc[k] + atan_turn(5'(k));
                    end else begin
                        r_x[k+1]   <= r_x[k] - (r_y[k] >>> k);
                        r_y[k+1]   <= r_y[k] + (r_x[k] >>> k);
                        r_acc[k+1] <= r_acc[k] - atan_turn(5'(k));
                    end
                    r_zero[k+1]  <= r_zero[k];
                    r_first[k+1] <= r_first[k];
                end
            end
        end
    endgenerate

    assign acc_rnd   = r_acc[NSTEPS] + {{(ACC_BITS-16){1'b0}}, 16'h8000};
    assign o_valid   = r_valid[NSTEPS];
    assign o_req.first = r_first[NSTEPS];
    assign o_req.raw   = r_zero[NSTEPS] ? '0 : acc_rnd[ACC_BITS-1:ACC_BITS-PHASE_BITS];

endmodule

// ===== rtl/cphu_fifo.sv =====
`timescale 1ns / 1ps
// Short queue of angle requests between the CORDIC front end and the unwrap stage.
module cphu_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cphu_pkg::t_phase_req i_data,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output cphu_pkg::t_phase_req o_data
);
    import cphu_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    t_phase_req      r_mem [0:FIFO_DEPTH-1];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [AW:0]     r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == (AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(FIFO_DEPTH-1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(FIFO_DEPTH-1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/cphu_unwrap.sv =====
`timescale 1ns / 1ps
// Back end: cumulative phase unwrap with a saturating turn offset and output register.
module cphu_unwrap (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  cphu_pkg::t_phase_req               i_req,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [cphu_pkg::UNWRAP_BITS-1:0]   o_unwrapped,
    output logic [cphu_pkg::PHASE_BITS-1:0]    o_raw
);
    import cphu_pkg::*;

    localparam int DW = PHASE_BITS + 2;
    localparam logic signed [DW-1:0] HALF_TURN = DW'(1) <<< (PHASE_BITS - 1);
    localparam logic signed [OFFSET_BITS-1:0] OFFSET_MAX = {1'b0, {(OFFSET_BITS-1){1'b1}}};
    localparam logic signed [OFFSET_BITS-1:0] OFFSET_MIN = {1'b1, {(OFFSET_BITS-1){1'b0}}};

    logic signed [PHASE_BITS-1:0]  r_prev;
    logic signed [OFFSET_BITS-1:0] r_off;
    logic                          r_valid;
    logic [UNWRAP_BITS-1:0]        r_unwrapped;
    logic [PHASE_BITS-1:0]         r_raw;

    logic signed [DW-1:0]          diff;
    logic signed [OFFSET_BITS-1:0] n_off;
    logic [UNWRAP_BITS-1:0]        n_unwrapped;
    logic                          load;

    assign load  = i_valid && (!r_valid || i_ready);
    assign o_pop = load;

    always_comb begin
        diff  = DW'($signed(i_req.raw)) - DW'(r_prev);
        n_off = r_off;
        if (i_req.first) begin
            n_off = '0;
        end else if (diff > HALF_TURN) begin
            if (r_off != OFFSET_MIN) begin
                n_off = r_off - 1'b1;
            end
        end else if (diff < -HALF_TURN) begin
            if (r_off != OFFSET_MAX) begin
                n_off = r_off + 1'b1;
            end
        end
        n_unwrapped = {n_off, {PHASE_BITS{1'b0}}}
                    + {{(UNWRAP_BITS-PHASE_BITS){i_req.raw[PHASE_BITS-1]}}, i_req.raw};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_prev  <= '0;
            r_off   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_prev  <= i_req.raw;
                r_off   <= n_off;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_unwrapped <= n_unwrapped;
            r_raw       <= i_req.raw;
        end
    end

    assign o_valid     = r_valid;
    assign o_unwrapped = r_unwrapped;
    assign o_raw       = r_raw;

endmodule

// ===== rtl/complex_phase_unwrap_top.sv =====
`timescale 1ns / 1ps
// Path: CORDIC input stage, one stage per rotation step, queue, output register.
// Throughput: one request per cycle while the front end is not halted.
// The front end halts only while its last stage holds a request and the queue is full.
// Reset (synchronous, active low) empties the pipeline and queue and clears the
// previous angle and turn offset to zero.
module complex_phase_unwrap_top #(
    parameter int CORDIC_STEPS = cphu_pkg::DEF_CORDIC_STEPS,
    parameter int SAMPLE_BITS  = cphu_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // sample_i [15:0], sample_q [31:16]
    input  logic [cphu_pkg::IN_TDATA_BITS-1:0]   i_s_axis_tdata,
    // first_of_vector
    input  logic                                 i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // unwrapped_phase [39:0], raw_phase [55:40]
    output logic [cphu_pkg::OUT_TDATA_BITS-1:0]  o_m_axis_tdata
);
    import cphu_pkg::*;

    logic       front_en;
    logic       front_valid;
    t_phase_req front_req;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    t_phase_req q_req;
    logic [UNWRAP_BITS-1:0] unwrapped;
    logic [PHASE_BITS-1:0]  raw;

    assign front_en        = !(front_valid && q_full);
    assign o_s_axis_tready = front_en;

    cphu_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_cordic (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .i_en       (front_en),
        .i_sample_i (i_s_axis_tdata[DATA_BITS-1:0]),
        .i_sample_q (i_s_axis_tdata[2*DATA_BITS-1:DATA_BITS]),
        .i_first    (i_s_axis_tuser),
        .o_valid    (front_valid),
        .o_req      (front_req)
    );

    cphu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_req),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_req)
    );

    cphu_unwrap u_unwrap (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!q_empty),
        .i_req       (q_req),
        .o_pop       (q_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_unwrapped (unwrapped),
        .o_raw       (raw)
    );

    assign o_m_axis_tdata = {raw, unwrapped};

endmodule

// ===== rtl/cphu_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the phase unwrap block and its bind to the top level.
module cphu_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_s_axis_tvalid,
    input logic                                 o_s_axis_tready,
    input logic [cphu_pkg::IN_TDATA_BITS-1:0]   i_s_axis_tdata,
    input logic                                 i_s_axis_tuser,
    input logic                                 o_m_axis_tvalid,
    input logic                                 i_m_axis_tready,
    input logic [cphu_pkg::OUT_TDATA_BITS-1:0]  o_m_axis_tdata
);
    import cphu_pkg::*;

    // The low bits of the unwrapped phase always equal the raw angle.
    a_low_bits_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[PHASE_BITS-1:0] ==
            o_m_axis_tdata[UNWRAP_BITS+PHASE_BITS-1:UNWRAP_BITS])
        else $error("unwrapped phase low bits differ from raw phase");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output request dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output data changed while stalled");

    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |-> !$isunknown({i_s_axis_tuser, i_s_axis_tdata}))
        else $error("input request accepted with unknown data");

endmodule

bind complex_phase_unwrap_top cphu_checker u_cphu_checker (.*);
